[rtl/core/qer_pkg.sv]
// Shared types, widths, constants and table helpers for the quad element residual block.
`default_nettype none
package qer_pkg;

  localparam int NST          = 13;   // register stages from request to result
  localparam int MAX_GRID_DIM = 4096;
  localparam int PAW          = 4;    // APB address width
  localparam int YW           = 44;   // biased dividend width of the constant dividers
  localparam int MW           = 40;   // cubic monomial width
  localparam int PW           = 48;   // weighted cubic sum width
  localparam int LINW         = 40;   // linear term width
  localparam int NMONO        = 40;   // every pair product times every corner

  // offsets that keep the constant dividers' dividends non-negative, and half-divisor rounding terms
  localparam logic [YW-1:0] QBIAS   = 44'd1 << 36;
  localparam logic [YW-1:0] BIAS6   = 44'd6 << 36;
  localparam logic [YW-1:0] BIAS75  = 44'd75 << 36;
  localparam logic [YW-1:0] HALF6   = 44'd3;
  localparam logic [PW-1:0] HALF1200 = 48'd600;

  typedef enum logic [1:0] {
    REG_STIFF = 2'd0,
    REG_REACT = 2'd1,
    REG_COLS  = 2'd2,
    REG_ROWS  = 2'd3
  } reg_idx_t;

  typedef logic signed [31:0] val_t;

  typedef struct packed {
    logic signed [31:0] u_corner0;
    logic signed [31:0] u_corner1;
    logic signed [31:0] u_corner2;
    logic signed [31:0] u_corner3;
    logic [11:0]        elem_col;
    logic [11:0]        elem_row;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] residual0;
    logic signed [31:0] residual1;
    logic signed [31:0] residual2;
    logic signed [31:0] residual3;
    logic               replace0;
    logic               replace1;
    logic               replace2;
    logic               replace3;
  } out_item_t;

  // cubic mass integral terms: sorted corner triple and integer weight
  localparam logic [1:0] CUB_A [20] = '{0,0,0,0,0,0,0,0,0,0,1,1,1,1,1,1,2,2,2,3};
  localparam logic [1:0] CUB_B [20] = '{0,0,0,0,1,1,1,2,2,3,1,1,1,2,2,3,2,2,3,3};
  localparam logic [1:0] CUB_C [20] = '{0,1,2,3,1,2,3,2,3,3,1,2,3,2,3,3,2,3,3,3};
  localparam logic [5:0] CUB_W [20] = '{48,36,9,36,24,12,18,4,12,24,
                                        12,9,6,6,8,6,3,6,9,12};

  // the ten corner pairs in lexical order
  localparam logic [1:0] PAIR_A [10] = '{0,0,0,0,1,1,1,2,2,3};
  localparam logic [1:0] PAIR_B [10] = '{0,1,2,3,1,2,3,2,3,3};

  function automatic int pair_index(input int a, input int b);
    int base;
    case (a)
      0: base = 0;
      1: base = 4;
      2: base = 7;
      default: base = 9;
    endcase
    return base + b - a;
  endfunction

  // monomial used by term t seen from corner k: the rounded product of the
  // first two factors, times the third, stored at 4 * pair + third corner
  function automatic int rot_index(input int k, input int t);
    int x, y, z, tmp;
    x = (k + int'(CUB_A[t])) & 3;
    y = (k + int'(CUB_B[t])) & 3;
    z = (k + int'(CUB_C[t])) & 3;
    if (x > y) begin
      tmp = x; x = y; y = tmp;
    end
    return 4 * pair_index(x, y) + z;
  endfunction

endpackage
`default_nettype wire

[rtl/core/qer_stream_if.sv]
// Valid/ready stream channel carrying one payload of parameter type T.
`default_nettype none
interface qer_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/qer_cdiv.sv]
// Four-stage long divider by a constant, four lanes, one 11-bit digit per stage.
`default_nettype none
module qer_cdiv #(
  parameter int D = 6
) (
  input  wire logic                   clk,
  input  wire logic [3:0]             en,
  input  wire logic [qer_pkg::YW-1:0] y [4],
  output logic      [qer_pkg::YW-1:0] q [4]
);
  localparam int NCH = 4;
  localparam int YW  = qer_pkg::YW;
  localparam int W   = YW / NCH;
  localparam int RW  = $clog2(D);
  localparam int VW  = RW + W;
  localparam int SH  = 24;
  localparam int M   = (1 << SH) / D;
  localparam int PRW = VW + SH;

  logic [YW-1:0] y_r   [NCH][4];
  logic [RW-1:0] rem_r [NCH][4];
  logic [YW-1:0] quo_r [NCH][4];

  for (genvar j = 0; j < NCH; j++) begin : g_stage
    for (genvar l = 0; l < 4; l++) begin : g_lane
      logic [YW-1:0]  y_p, quo_p;
      logic [RW-1:0]  rem_p, rem_n;
      logic [VW-1:0]  v, r;
      logic [PRW-1:0] prod;
      logic [W-1:0]   est, dig;

      if (j == 0) begin : g_first
        assign y_p   = y[l];
        assign rem_p = '0;
        assign quo_p = '0;
      end else begin : g_next
        assign y_p   = y_r[j-1][l];
        assign rem_p = rem_r[j-1][l];
        assign quo_p = quo_r[j-1][l];
      end

      // reciprocal estimate is exact or one short; fix with one compare
      always_comb begin
        v    = {rem_p, y_p[YW-1-j*W -: W]};
        prod = PRW'(v) * PRW'(M);
        est  = prod[SH +: W];
        r    = v - VW'(est) * VW'(D);
        if (r >= VW'(D)) begin
          dig   = est + 1'b1;
          rem_n = RW'(r - VW'(D));
        end else begin
          dig   = est;
          rem_n = RW'(r);
        end
      end

      always_ff @(posedge clk) begin
        if (en[j]) begin
          y_r[j][l]   <= y_p;
          rem_r[j][l] <= rem_n;
          quo_r[j][l] <= {quo_p[YW-W-1:0], dig};
        end
      end
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_out
    assign q[l] = quo_r[NCH-1][l];
  end
endmodule
`default_nettype wire

[rtl/core/qer_linear.sv]
// Stiffness term: stencil sum, split scale multiply, rounding and bias for divide by six.
`default_nettype none
module qer_linear (
  input  wire logic                   clk,
  input  wire logic [3:1]             en,
  input  wire qer_pkg::val_t          u [4],
  input  wire logic [30:0]            stiff,
  output logic      [qer_pkg::YW-1:0] y6 [4]
);
  localparam int SW = 36;

  for (genvar k = 0; k < 4; k++) begin : g_corner
    logic signed [SW-1:0] s_r, s_n, e0, e1, e2, e3;
    logic signed [19:0]   sh;
    logic signed [51:0]   ph_r;
    logic        [46:0]   pl_r;
    logic        [67:0]   prod;
    logic        [39:0]   mq;

    assign e0  = {{(SW-32){u[k][31]}}, u[k]};
    assign e1  = {{(SW-32){u[(k+1)%4][31]}}, u[(k+1)%4]};
    assign e2  = {{(SW-32){u[(k+2)%4][31]}}, u[(k+2)%4]};
    assign e3  = {{(SW-32){u[(k+3)%4][31]}}, u[(k+3)%4]};
    assign s_n = (e0 <<< 2) - e1 - (e2 <<< 1) - e3;
    assign sh  = s_r[35:16];

    always_comb begin
      prod = {ph_r, 16'b0} + {21'b0, pl_r} + (68'd1 << 27);
      mq   = prod[67:28];
    end

    always_ff @(posedge clk) begin
      if (en[1]) s_r <= s_n;
      if (en[2]) begin
        ph_r <= sh * $signed({1'b0, stiff});
        pl_r <= 47'(s_r[15:0]) * 47'(stiff);
      end
      if (en[3]) y6[k] <= {{4{mq[39]}}, mq} + qer_pkg::HALF6 + qer_pkg::BIAS6;
    end
  end
endmodule
`default_nettype wire

[rtl/core/qer_cubic.sv]
// Cubic term: pair products, monomials, weighted sums and bias for divide by 1200.
`default_nettype none
module qer_cubic (
  input  wire logic                   clk,
  input  wire logic [6:1]             en,
  input  wire qer_pkg::val_t          u [4],
  output logic      [qer_pkg::YW-1:0] y75 [4]
);
  localparam int MW = qer_pkg::MW;
  localparam int PW = qer_pkg::PW;
  localparam int NM = qer_pkg::NMONO;

  qer_pkg::val_t      u1_r [4];
  qer_pkg::val_t      u2_r [4];
  logic signed [63:0] pp_r [10];
  logic        [35:0] q_r  [10];
  logic signed [51:0] mh_r [NM];
  logic signed [48:0] ml_r [NM];
  logic        [MW-1:0] m_r [NM];
  logic        [PW-1:0] part_r [4][4];

  always_ff @(posedge clk) begin
    if (en[1]) u1_r <= u;
    if (en[2]) u2_r <= u1_r;
  end

  // stage 1 and 2: rounded pair products
  for (genvar p = 0; p < 10; p++) begin : g_pair
    logic [63:0] rq;
    assign rq = pp_r[p] + (64'd1 << 27);
    always_ff @(posedge clk) begin
      if (en[1]) pp_r[p] <= u[qer_pkg::PAIR_A[p]] * u[qer_pkg::PAIR_B[p]];
      if (en[2]) q_r[p]  <= rq[63:28];
    end
  end

  // stage 3 and 4: every pair times every corner, third factor in two partial products
  for (genvar j = 0; j < NM; j++) begin : g_mono
    localparam int PI = j >> 2;
    localparam int CI = j & 3;
    logic signed [19:0] qh;
    logic        [67:0] prod;
    assign qh   = q_r[PI][35:16];
    assign prod = {mh_r[j], 16'b0} + {{19{ml_r[j][48]}}, ml_r[j]} + (68'd1 << 27);
    always_ff @(posedge clk) begin
      if (en[3]) begin
        mh_r[j] <= qh * u2_r[CI];
        ml_r[j] <= $signed({1'b0, q_r[PI][15:0]}) * u2_r[CI];
      end
      if (en[4]) m_r[j] <= prod[67:28];
    end
  end

  // stage 5 and 6: weighted sums per corner in four groups, then total
  for (genvar k = 0; k < 4; k++) begin : g_corner
    logic [PW-1:0] tot;
    for (genvar g = 0; g < 4; g++) begin : g_grp
      logic [PW-1:0] acc;
      always_comb begin
        acc = '0;
        for (int t = g * 5; t < g * 5 + 5; t++) begin
          acc = acc + {{(PW-MW){m_r[qer_pkg::rot_index(k, t)][MW-1]}},
                       m_r[qer_pkg::rot_index(k, t)]} * PW'(qer_pkg::CUB_W[t]);
        end
      end
      always_ff @(posedge clk) begin
        if (en[5]) part_r[k][g] <= acc;
      end
    end
    assign tot = part_r[k][0] + part_r[k][1] + part_r[k][2] + part_r[k][3]
                 + qer_pkg::HALF1200;
    always_ff @(posedge clk) begin
      if (en[6]) y75[k] <= tot[PW-1:4] + qer_pkg::BIAS75;
    end
  end
endmodule
`default_nettype wire

[rtl/core/quad_element_residual.sv]
// Top level of the bilinear quad element residual pipeline.
//
// One element request (four corner values in signed Q4.28 plus its column and
// row) enters per clock unless the result port is blocked and every stage is
// full, and its four residual contributions leave from the registered last
// stage. The pipeline holds full 32x32 multiplies for the pair products, split
// multiplies for the monomials and both scale factors, and two four-stage
// constant dividers (divide by six for the stiffness term, by 1200 for the
// cubic term). Each stage holds its own valid bit and only stalls when it and
// every stage after it are full, so bubbles are squeezed out while the result
// port is blocked. Corners on the domain boundary return their own value with
// the replace flag set. The four configuration registers sit behind an APB port
// at byte addresses 0, 4, 8 and 12; write them only while the pipeline is empty.
`default_nettype none
module quad_element_residual (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [qer_pkg::PAW-1:0]  paddr,
  input  wire logic [31:0]              pwdata,
  output logic      [31:0]              prdata,
  output logic                          pready,
  qer_stream_if.sink                    elem,
  qer_stream_if.source                  resid
);
  localparam int NST  = qer_pkg::NST;
  localparam int YW   = qer_pkg::YW;
  localparam int LINW = qer_pkg::LINW;

  // configuration registers
  logic [30:0] stiff, react;
  logic [12:0] cols, rows;
  qer_pkg::reg_idx_t ridx;

  assign ridx   = qer_pkg::reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stiff <= '0;
      react <= '0;
      cols  <= 13'd2;
      rows  <= 13'd2;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        qer_pkg::REG_STIFF: stiff <= pwdata[30:0];
        qer_pkg::REG_REACT: react <= pwdata[30:0];
        qer_pkg::REG_COLS:  cols  <= pwdata[12:0];
        qer_pkg::REG_ROWS:  rows  <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      qer_pkg::REG_STIFF: prdata = {1'b0, stiff};
      qer_pkg::REG_REACT: prdata = {1'b0, react};
      qer_pkg::REG_COLS:  prdata = {19'b0, cols};
      qer_pkg::REG_ROWS:  prdata = {19'b0, rows};
      default:            prdata = '0;
    endcase
  end

  // pipeline control: a stage advances when it is empty or anything after it can move
  logic [NST:1] v;
  logic [NST:1] en;

  for (genvar s = 1; s <= NST; s++) begin : g_en
    assign en[s] = resid.ready || (v[NST:s] != '1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= elem.valid;
      for (int s = 2; s <= NST; s++) begin
        if (en[s]) v[s] <= v[s-1];
      end
    end
  end

  assign elem.ready  = en[1];
  assign resid.valid = v[NST];

  // boundary tests against the clamped grid size
  qer_pkg::val_t u_in [4];
  logic [12:0]   mx, my;
  logic [13:0]   mxm2, mym2, ie, je;
  logic [3:0]    rep_in;

  assign u_in[0] = elem.data.u_corner0;
  assign u_in[1] = elem.data.u_corner1;
  assign u_in[2] = elem.data.u_corner2;
  assign u_in[3] = elem.data.u_corner3;

  always_comb begin
    mx   = (cols > 13'(qer_pkg::MAX_GRID_DIM)) ? 13'(qer_pkg::MAX_GRID_DIM) : cols;
    my   = (rows > 13'(qer_pkg::MAX_GRID_DIM)) ? 13'(qer_pkg::MAX_GRID_DIM) : rows;
    // below two the difference wraps to a negative code that no index matches
    mxm2 = {1'b0, mx} - 14'd2;
    mym2 = {1'b0, my} - 14'd2;
    ie   = {2'b0, elem.data.elem_col};
    je   = {2'b0, elem.data.elem_row};
    rep_in[0] = (ie == 14'd0) || (je == 14'd0);
    rep_in[1] = (ie == mxm2)  || (je == 14'd0);
    rep_in[2] = (ie == mxm2)  || (je == mym2);
    rep_in[3] = (ie == 14'd0) || (je == mym2);
  end

  // corner values and flags ride alongside the arithmetic
  qer_pkg::val_t u_d   [1:NST-1][4];
  logic [3:0]    rep_d [1:NST-1];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      u_d[1]   <= u_in;
      rep_d[1] <= rep_in;
    end
    for (int s = 2; s < NST; s++) begin
      if (en[s]) begin
        u_d[s]   <= u_d[s-1];
        rep_d[s] <= rep_d[s-1];
      end
    end
  end

  // stiffness term: stages 1 to 7
  logic [YW-1:0] y6 [4];
  logic [YW-1:0] q6 [4];

  qer_linear u_linear (
    .clk   (clk),
    .en    (en[3:1]),
    .u     (u_in),
    .stiff (stiff),
    .y6    (y6)
  );

  qer_cdiv #(.D(6)) u_div6 (
    .clk (clk),
    .en  (en[7:4]),
    .y   (y6),
    .q   (q6)
  );

  // cubic term: stages 1 to 10
  logic [YW-1:0] y75 [4];
  logic [YW-1:0] q75 [4];

  qer_cubic u_cubic (
    .clk (clk),
    .en  (en[6:1]),
    .u   (u_in),
    .y75 (y75)
  );

  qer_cdiv #(.D(75)) u_div75 (
    .clk (clk),
    .en  (en[10:7]),
    .y   (y75),
    .q   (q75)
  );

  // stages 11 to 13: reaction scale in two partial products, its rounding, then difference and saturation
  logic signed [55:0] ph_r [4];
  logic        [46:0] pl_r [4];
  logic        [43:0] nl_r [4];
  qer_pkg::val_t      res  [4];
  qer_pkg::out_item_t out_r;

  for (genvar k = 0; k < 4; k++) begin : g_tail
    logic [LINW-1:0]    lin_d [8:12];
    logic [YW-1:0]      lin7w, pdw;
    logic signed [23:0] pdh;
    logic [71:0]        prod;
    logic [45:0]        diff;

    assign lin7w = q6[k] - qer_pkg::QBIAS;
    assign pdw   = q75[k] - qer_pkg::QBIAS;
    assign pdh   = pdw[39:16];
    assign prod  = {ph_r[k], 16'b0} + {25'b0, pl_r[k]} + (72'd1 << 27);
    assign diff  = {{6{lin_d[12][LINW-1]}}, lin_d[12]}
                   - {{2{nl_r[k][43]}}, nl_r[k]};

    // boundary corners pass their own value; others clamp to the signed 32 bit range when the upper bits disagree
    always_comb begin
      if (rep_d[NST-1][k]) begin
        res[k] = u_d[NST-1][k];
      end else if (!diff[45] && (diff[44:31] != '0)) begin
        res[k] = 32'sh7FFFFFFF;
      end else if (diff[45] && (diff[44:31] != '1)) begin
        res[k] = 32'sh80000000;
      end else begin
        res[k] = diff[31:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en[8]) lin_d[8] <= lin7w[LINW-1:0];
      for (int s = 9; s <= 12; s++) begin
        if (en[s]) lin_d[s] <= lin_d[s-1];
      end
      if (en[11]) begin
        ph_r[k] <= pdh * $signed({1'b0, react});
        pl_r[k] <= 47'(pdw[15:0]) * 47'(react);
      end
      if (en[12]) nl_r[k] <= prod[71:28];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NST]) begin
      out_r.residual0 <= res[0];
      out_r.residual1 <= res[1];
      out_r.residual2 <= res[2];
      out_r.residual3 <= res[3];
      out_r.replace0  <= rep_d[NST-1][0];
      out_r.replace1  <= rep_d[NST-1][1];
      out_r.replace2  <= rep_d[NST-1][2];
      out_r.replace3  <= rep_d[NST-1][3];
    end
  end

  assign resid.data = out_r;
endmodule
`default_nettype wire

[rtl/core/qer_check.sv]
// Port-level checker for the quad element residual block and its bind.
`default_nettype none
module qer_check (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire qer_pkg::out_item_t      out_data,
  input wire logic                    psel,
  input wire logic                    penable,
  input wire logic                    pwrite,
  input wire logic [qer_pkg::PAW-1:0] paddr,
  input wire logic [31:0]             pwdata,
  input wire logic [31:0]             prdata
);
  // nothing leaves the pipeline straight after reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a blocked result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("blocked result changed");

  // an empty output stage must let requests in
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // stiffness register reads back what was written
  a_readback: assert property (@(posedge clk) disable iff (rst)
    $past(psel && penable && pwrite && !rst)
    && ($past(paddr[3:2]) == 2'(qer_pkg::REG_STIFF))
    && (paddr[3:2] == 2'(qer_pkg::REG_STIFF))
    |-> prdata == {1'b0, $past(pwdata[30:0])})
    else $error("stiffness register readback mismatch");
endmodule

bind quad_element_residual qer_check u_check (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (elem.ready),
  .out_valid (resid.valid),
  .out_ready (resid.ready),
  .out_data  (resid.data),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);
`default_nettype wire
